/* design/oapm_pkg.sv */
package oapm_pkg;

	// table geometry
	localparam int TABLE_SLOTS = 4096;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int COUNT_W     = SLOT_W + 1;
	// inserts are refused once filled slots would reach three quarters of the table
	localparam int LOAD_LIMIT  = TABLE_SLOTS * 3 / 4;

	// configuration register index
	localparam logic REG_TRACKING = 1'b0;

	// transaction fields
	localparam int KEY_W          = 64;
	localparam int SIZE_W         = 48;
	localparam int STATUS_W       = 3;
	localparam int SLOT_FIELD_W   = 12;
	localparam int LIVE_FIELD_W   = 13;
	localparam int ORPHAN_W       = 32;
	localparam int IN_DATA_W      = KEY_W + SIZE_W;
	localparam int OUT_FIELDS_W   = SLOT_FIELD_W + LIVE_FIELD_W + ORPHAN_W;
	localparam int OUT_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W      = OUT_DATA_W - OUT_FIELDS_W;

	// opcodes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_ERASE  = 1'b1;

	// slot marks
	typedef logic [1:0] mark_t;
	localparam mark_t MARK_EMPTY   = 2'd0;
	localparam mark_t MARK_LIVE    = 2'd1;
	localparam mark_t MARK_DELETED = 2'd2;

	// murmur 64-bit finalizer
	localparam logic [KEY_W-1:0] HASH_C1 = 64'hff51afd7ed558ccd;
	localparam logic [KEY_W-1:0] HASH_C2 = 64'hc4ceb9fe1a85ec53;
	localparam int HASH_SHIFT = 33;

	typedef enum logic [STATUS_W-1:0] {
		ST_IGNORED  = 3'd0,
		ST_NEW      = 3'd1,
		ST_REPLACED = 3'd2,
		ST_ERASED   = 3'd3,
		ST_ORPHAN   = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic latch_in;
		logic decide;
		logic hash_start;
		logic probe_init;
		logic probe_rd;
		logic probe_step;
		logic apply;
		logic load_out;
		logic clear_step;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_done;
		logic ignore;
		logic insert;
		logic over_limit;
		logic no_live;
		logic hash_done;
		logic probe_done;
	} stat_t;

endpackage

/* design/oapm_hash.sv */
module oapm_hash (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [oapm_pkg::KEY_W-1:0]   key,
	output logic                         done,
	output logic [oapm_pkg::SLOT_W-1:0]  hash
);
	import oapm_pkg::*;

	// one 32x32 multiplier; each 64-bit product takes three partial products,
	// then an xor-shift step
	logic [KEY_W-1:0] x_q, acc_q, coef, acc_next;
	logic [31:0]      mul_a, mul_b;
	logic [63:0]      prod;
	logic             busy_q, done_q, round_q;
	logic [1:0]       phase_q;

	always_comb begin
		coef  = round_q ? HASH_C2 : HASH_C1;
		mul_a = (phase_q == 2'd1) ? x_q[63:32] : x_q[31:0];
		mul_b = (phase_q == 2'd2) ? coef[63:32] : coef[31:0];
		prod  = mul_a * mul_b;
		if (phase_q == 2'd0) begin
			acc_next = prod;
		end else begin
			acc_next = acc_q + {prod[31:0], 32'h0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			round_q <= 1'b0;
			phase_q <= 2'd0;
		end else if (start) begin
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			round_q <= 1'b0;
			phase_q <= 2'd0;
		end else begin
			done_q <= busy_q && (phase_q == 2'd3) && round_q;
			if (busy_q) begin
				phase_q <= phase_q + 2'd1;
				if (phase_q == 2'd3) begin
					if (round_q) begin
						busy_q <= 1'b0;
					end
					round_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= key ^ (key >> HASH_SHIFT);
		end else if (busy_q) begin
			if (phase_q == 2'd3) begin
				x_q <= acc_q ^ (acc_q >> HASH_SHIFT);
			end else begin
				acc_q <= acc_next;
			end
		end
	end

	assign done = done_q;
	assign hash = x_q[SLOT_W-1:0];

endmodule

/* design/oapm_datapath.sv */
module oapm_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  oapm_pkg::cmd_t                      cmd,
	output oapm_pkg::stat_t                     stat,
	input  logic                                enable,
	input  logic                                opcode,
	input  logic [oapm_pkg::KEY_W-1:0]          address_key,
	input  logic [oapm_pkg::SIZE_W-1:0]         alloc_size,
	output oapm_pkg::status_t                   out_status,
	output logic [oapm_pkg::SLOT_FIELD_W-1:0]   out_slot,
	output logic [oapm_pkg::LIVE_FIELD_W-1:0]   out_live,
	output logic [oapm_pkg::ORPHAN_W-1:0]       out_orphan
);
	import oapm_pkg::*;

	// table storage
	mark_t             mark_mem [TABLE_SLOTS];
	logic [KEY_W-1:0]  key_mem  [TABLE_SLOTS];
	logic [SIZE_W-1:0] size_mem [TABLE_SLOTS];

	logic              op_q;
	logic [KEY_W-1:0]  key_q;
	logic [SIZE_W-1:0] size_q;

	mark_t             mark_rd_q;
	logic [KEY_W-1:0]  key_rd_q;

	logic [SLOT_W-1:0] idx_q, home_q, tomb_q, tgt_q, n_q, clr_q, res_slot_q;
	logic              have_tomb_q, found_q, tgt_empty_q;
	logic [COUNT_W-1:0] live_q, filled_q;
	logic [ORPHAN_W-1:0] orphan_q;
	status_t           res_status_q;

	logic              hash_done;
	logic [SLOT_W-1:0] hash;

	logic              is_empty, is_live, is_tomb, match, last, probe_done;
	logic [SLOT_W-1:0] tomb_now, mark_waddr;
	logic              have_now, mark_we;
	mark_t             mark_wdata;

	oapm_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.hash_start),
		.key    (key_q),
		.done   (hash_done),
		.hash   (hash)
	);

	// probe decision on the slot just read
	always_comb begin
		is_empty   = (mark_rd_q == MARK_EMPTY);
		is_live    = (mark_rd_q == MARK_LIVE);
		is_tomb    = !is_empty && !is_live;
		match      = is_live && (key_rd_q == key_q);
		last       = (n_q == {SLOT_W{1'b1}});
		probe_done = is_empty || match || last;
		have_now   = have_tomb_q || is_tomb;
		tomb_now   = have_tomb_q ? tomb_q : idx_q;
	end

	always_comb begin
		stat.clear_done = (clr_q == {SLOT_W{1'b1}});
		stat.ignore     = !enable || (key_q == '0);
		stat.insert     = (op_q == OP_INSERT);
		stat.over_limit = ({1'b0, filled_q} + (COUNT_W+1)'(1)) >= (COUNT_W+1)'(LOAD_LIMIT);
		stat.no_live    = (live_q == '0);
		stat.hash_done  = hash_done;
		stat.probe_done = probe_done;
	end

	// mark write port shared by the clearing sweep and the update
	always_comb begin
		mark_we    = cmd.clear_step || (cmd.apply && (op_q == OP_INSERT || found_q));
		mark_waddr = cmd.clear_step ? clr_q : tgt_q;
		if (cmd.clear_step) begin
			mark_wdata = MARK_EMPTY;
		end else if (op_q == OP_INSERT) begin
			mark_wdata = MARK_LIVE;
		end else begin
			mark_wdata = MARK_DELETED;
		end
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_waddr] <= mark_wdata;
		end
		if (cmd.probe_rd) begin
			mark_rd_q <= mark_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && op_q == OP_INSERT) begin
			key_mem[tgt_q] <= key_q;
		end
		if (cmd.probe_rd) begin
			key_rd_q <= key_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && op_q == OP_INSERT) begin
			size_mem[tgt_q] <= size_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q   <= opcode;
			key_q  <= address_key;
			size_q <= alloc_size;
		end
		if (cmd.probe_init) begin
			idx_q  <= hash;
			home_q <= hash;
		end else if (cmd.probe_step) begin
			if (probe_done) begin
				if (match) begin
					tgt_q <= idx_q;
				end else if (is_empty) begin
					tgt_q <= tomb_now;
				end else begin
					tgt_q <= have_now ? tomb_now : home_q;
				end
			end else begin
				idx_q <= idx_q + 1'b1;
				if (is_tomb && !have_tomb_q) begin
					tomb_q <= idx_q;
				end
			end
		end
		if (cmd.load_out) begin
			out_status <= res_status_q;
			out_slot   <= SLOT_FIELD_W'(res_slot_q);
			out_live   <= LIVE_FIELD_W'(live_q);
			out_orphan <= orphan_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			n_q          <= '0;
			have_tomb_q  <= 1'b0;
			found_q      <= 1'b0;
			tgt_empty_q  <= 1'b0;
			live_q       <= '0;
			filled_q     <= '0;
			orphan_q     <= '0;
			res_status_q <= ST_IGNORED;
			res_slot_q   <= '0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.latch_in) begin
				found_q <= 1'b0;
			end
			if (cmd.decide) begin
				res_status_q <= stat.ignore ? ST_IGNORED : ST_FULL;
				res_slot_q   <= '0;
			end
			if (cmd.probe_init) begin
				n_q         <= '0;
				have_tomb_q <= 1'b0;
			end else if (cmd.probe_step) begin
				if (probe_done) begin
					found_q     <= match;
					tgt_empty_q <= is_empty && !have_tomb_q;
				end else begin
					n_q <= n_q + 1'b1;
					if (is_tomb) begin
						have_tomb_q <= 1'b1;
					end
				end
			end
			if (cmd.apply) begin
				if (op_q == OP_INSERT) begin
					res_slot_q <= tgt_q;
					if (found_q) begin
						res_status_q <= ST_REPLACED;
					end else begin
						res_status_q <= ST_NEW;
						live_q       <= live_q + 1'b1;
						if (tgt_empty_q) begin
							filled_q <= filled_q + 1'b1;
						end
					end
				end else if (found_q) begin
					res_status_q <= ST_ERASED;
					res_slot_q   <= tgt_q;
					live_q       <= live_q - 1'b1;
				end else begin
					res_status_q <= ST_ORPHAN;
					res_slot_q   <= '0;
					if (orphan_q != {ORPHAN_W{1'b1}}) begin
						orphan_q <= orphan_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

/* design/oapm_ctrl.sv */
module oapm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  oapm_pkg::stat_t stat,
	output oapm_pkg::cmd_t  cmd
);
	import oapm_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECIDE,
		S_HASH,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_APPLY,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;

	always_comb begin
		cmd            = '0;
		cmd.clear_step = (state_q == S_CLEAR);
		cmd.latch_in   = (state_q == S_IDLE) && s_tvalid;
		cmd.decide     = (state_q == S_DECIDE);
		cmd.hash_start = (state_q == S_DECIDE);
		cmd.probe_init = (state_q == S_HASH);
		cmd.probe_rd   = (state_q == S_PROBE_RD);
		cmd.probe_step = (state_q == S_PROBE_CHK);
		cmd.apply      = (state_q == S_APPLY);
		cmd.load_out   = (state_q == S_FINISH) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (stat.clear_done) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (stat.ignore || (stat.insert && stat.over_limit)) begin
						state_q <= S_FINISH;
					end else if (!stat.insert && stat.no_live) begin
						state_q <= S_APPLY;
					end else begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (stat.hash_done) begin
						state_q <= S_PROBE_RD;
					end
				end
				S_PROBE_RD: begin
					state_q <= S_PROBE_CHK;
				end
				S_PROBE_CHK: begin
					state_q <= stat.probe_done ? S_APPLY : S_PROBE_RD;
				end
				S_APPLY: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (cmd.load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

endmodule

/* design/open_address_pointer_map.sv */
// Live-allocation tracker: an open-addressing table of TABLE_SLOTS slots keyed by a
// 64-bit address, hashed with the murmur 64-bit finalizer and probed linearly, reusing
// the first deleted slot on the path. Each input transaction (tuser = opcode, 0 insert,
// 1 free) returns one result transaction with status, slot, live count and saturating
// orphan count. After reset the block sweeps the slot marks to empty, one slot per
// cycle, and holds s_tready low meanwhile; APB writes are taken throughout. Items are
// handled one at a time. Ignored items and full-table inserts go from the decision
// straight to the result, a free on an empty table passes through the update step
// only, and a hashed item runs the hash and then probes slot by slot: the hash runs on
// a single shared 32x32 multiplier (three partial products plus one xor-shift step per
// round, two rounds), and each probe step is a registered read of the mark/key memory
// followed by a compare. The next item is accepted while a finished result still
// waits on m_tready. Inserts are refused with status full once filled slots (live
// plus deleted) would reach three quarters of the table; there is no rehash.
module open_address_pointer_map
	import oapm_pkg::*;
(
	input  logic                                clk,
	input  logic                                arst_n,
	// APB configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [oapm_pkg::IN_DATA_W-1:0]      s_tdata,   // address_key[63:0], alloc_size[111:64]
	input  logic [0:0]                          s_tuser,   // opcode[0]
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [oapm_pkg::OUT_DATA_W-1:0]     m_tdata,   // slot_index[11:0], live_count[24:12],
	                                                       // orphan_count[56:25], zero pad
	output logic [oapm_pkg::STATUS_W-1:0]       m_tuser    // status[2:0]
);

	logic                    enable_q;
	logic                    reg_idx;
	logic                    cfg_wr;
	cmd_t                    cmd;
	stat_t                   stat;
	status_t                 out_status;
	logic [SLOT_FIELD_W-1:0] out_slot;
	logic [LIVE_FIELD_W-1:0] out_live;
	logic [ORPHAN_W-1:0]     out_orphan;

	// register file: one bit at offset 0; word index is paddr[2]
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_TRACKING);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_wr) begin
			enable_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_TRACKING) begin
			prdata = {31'b0, enable_q};
		end
	end

	oapm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	oapm_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.enable      (enable_q),
		.opcode      (s_tuser[0]),
		.address_key (s_tdata[KEY_W-1:0]),
		.alloc_size  (s_tdata[IN_DATA_W-1:KEY_W]),
		.out_status  (out_status),
		.out_slot    (out_slot),
		.out_live    (out_live),
		.out_orphan  (out_orphan)
	);

	assign m_tdata = {{OUT_PAD_W{1'b0}}, out_orphan, out_live, out_slot};
	assign m_tuser = out_status;

	// live entries can never pass the load limit
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_live < LIVE_FIELD_W'(LOAD_LIMIT)))
		else $error("live count beyond load limit");

	// results that touch no slot report slot zero
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_status == ST_IGNORED || out_status == ST_ORPHAN ||
		out_status == ST_FULL) |-> (out_slot == '0))
		else $error("nonzero slot on untouched result");

	// one transaction in work at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// a stalled result holds still until taken
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

endmodule

/* sim/tb_open_address_pointer_map.sv */
`timescale 1ns / 100ps

// Allocation tracker testbench. The scoreboard below keeps its own copy of the
// open-addressing table and computes one expected result per accepted input
// transaction. Results are checked in order as they leave the master side.
module tb_open_address_pointer_map;
	import oapm_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 1080;
	localparam int IGNORED_RUN  = 30;
	localparam int TAIL_CYCLES  = 40;
	// reset sweep plus ~1.2k transactions under heavy stalls, many times over
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int MAX_REPORTS  = 10;

	localparam logic [KEY_W-1:0] NULL_KEY     = '0;
	localparam logic [KEY_W-1:0] ONES_KEY     = '1;
	localparam logic [SIZE_W-1:0] MAX_SIZE    = '1;

	typedef struct {
		logic [STATUS_W-1:0]     status;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [LIVE_FIELD_W-1:0] live;
		logic [ORPHAN_W-1:0]     orphan;
	} alloc_result_t;

	// Table model plus queue of expected results.
	class alloc_scoreboard;
		mark_t             mark[TABLE_SLOTS];
		logic [KEY_W-1:0]  key_at[TABLE_SLOTS];
		logic [SIZE_W-1:0] size_at[TABLE_SLOTS];
		int unsigned       live_cnt;
		int unsigned       filled_cnt;
		logic [ORPHAN_W-1:0] orphan_cnt;
		bit                armed;
		alloc_result_t     result_q[$];
		int unsigned       n_checked;
		int unsigned       errors;

		function new();
			foreach (mark[i]) mark[i] = MARK_EMPTY;
			live_cnt   = 0;
			filled_cnt = 0;
			orphan_cnt = '0;
			armed      = 1'b0;
			n_checked  = 0;
			errors     = 0;
		endfunction

		function void report(string what);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("[%0t] mismatch %0d: %s", $time, errors, what);
		endfunction

		// murmur 64-bit finalizer, low bits pick the home slot
		function int unsigned home_of(logic [KEY_W-1:0] k);
			logic [KEY_W-1:0] h;
			h = k ^ (k >> HASH_SHIFT);
			h = h * HASH_C1;
			h = h ^ (h >> HASH_SHIFT);
			h = h * HASH_C2;
			h = h ^ (h >> HASH_SHIFT);
			return int'(h & KEY_W'(TABLE_SLOTS - 1));
		endfunction

		// live slot holding the key, else first tombstone before an empty slot,
		// else that empty slot; with no empty slot, the first tombstone, else the home slot
		function int unsigned find_slot(logic [KEY_W-1:0] k);
			int unsigned home;
			int unsigned idx;
			int unsigned tomb;
			bit have_tomb;
			home      = home_of(k);
			idx       = home;
			tomb      = 0;
			have_tomb = 1'b0;
			for (int n = 0; n < TABLE_SLOTS; n++) begin
				if (mark[idx] == MARK_EMPTY)
					return have_tomb ? tomb : idx;
				if (mark[idx] == MARK_LIVE) begin
					if (key_at[idx] == k)
						return idx;
				end else if (!have_tomb) begin
					have_tomb = 1'b1;
					tomb      = idx;
				end
				idx = (idx + 1) % TABLE_SLOTS;
			end
			return have_tomb ? tomb : home;
		endfunction

		function status_t note_item(logic op, logic [KEY_W-1:0] k, logic [SIZE_W-1:0] sz);
			alloc_result_t r;
			int unsigned idx;
			r.status = ST_IGNORED;
			r.slot   = '0;
			if (armed && k != NULL_KEY) begin
				if (op == OP_INSERT) begin
					// refused at the load threshold, even for a key already present
					if ((filled_cnt + 1) * 4 >= TABLE_SLOTS * 3) begin
						r.status = ST_FULL;
					end else begin
						idx = find_slot(k);
						if (mark[idx] == MARK_LIVE && key_at[idx] == k) begin
							r.status = ST_REPLACED;
						end else begin
							// a reused tombstone leaves the filled count alone
							if (mark[idx] == MARK_EMPTY)
								filled_cnt++;
							live_cnt++;
							r.status = ST_NEW;
						end
						mark[idx]    = MARK_LIVE;
						key_at[idx]  = k;
						size_at[idx] = sz;
						r.slot       = SLOT_FIELD_W'(idx);
					end
				end else begin
					idx = (live_cnt != 0) ? find_slot(k) : 0;
					if (live_cnt != 0 && mark[idx] == MARK_LIVE && key_at[idx] == k) begin
						mark[idx] = MARK_DELETED;
						live_cnt--;
						r.status = ST_ERASED;
						r.slot   = SLOT_FIELD_W'(idx);
					end else begin
						if (orphan_cnt != '1)
							orphan_cnt++;
						r.status = ST_ORPHAN;
					end
				end
			end
			r.live   = LIVE_FIELD_W'(live_cnt);
			r.orphan = orphan_cnt;
			result_q.push_back(r);
			return status_t'(r.status);
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [SLOT_FIELD_W-1:0] slot,
				logic [LIVE_FIELD_W-1:0] live, logic [ORPHAN_W-1:0] orphan);
			alloc_result_t e;
			if (result_q.size() == 0) begin
				report($sformatf("unexpected result: status %0d slot %0d live %0d orphan %0d",
					st, slot, live, orphan));
				return;
			end
			e = result_q.pop_front();
			if (st !== e.status || slot !== e.slot || live !== e.live || orphan !== e.orphan)
				report($sformatf({"result %0d exp/got: status %0d/%0d slot %0d/%0d",
					" live %0d/%0d orphan %0d/%0d"}, n_checked, e.status, st,
					e.slot, slot, e.live, live, e.orphan, orphan));
			n_checked++;
		endfunction
	endclass

	// clock, reset, block inputs: all known from time zero
	logic                    clk      = 1'b0;
	logic                    arst_n   = 1'b0;
	logic                    psel     = 1'b0;
	logic                    penable  = 1'b0;
	logic                    pwrite   = 1'b0;
	logic [2:0]              paddr    = '0;
	logic [31:0]             pwdata   = '0;
	logic [31:0]             prdata;
	logic                    pready;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [IN_DATA_W-1:0]    s_tdata  = '0;   // address_key[63:0], alloc_size[111:64]
	logic [0:0]              s_tuser  = '0;   // opcode[0]
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_tdata;         // slot_index[11:0], live_count[24:12],
	                                          // orphan_count[56:25], zero pad
	logic [STATUS_W-1:0]     m_tuser;         // status[2:0]

	alloc_scoreboard  sb;
	int unsigned      send_idle = 0;   // percent of cycles the sender holds off
	int unsigned      recv_idle = 0;   // percent of cycles the receiver stalls
	int unsigned      cycle_cnt = 0;
	logic [KEY_W-1:0] live_q[$];       // keys the model holds live
	logic [KEY_W-1:0] dead_q[$];       // keys that were erased at some point

	open_address_pointer_map dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAIL open_address_pointer_map");
			$finish;
		end
	end

	// receiver: random back-pressure at the current stall rate
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// result monitor; values sampled here are the ones from before this edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata[SLOT_FIELD_W-1:0],
				m_tdata[SLOT_FIELD_W +: LIVE_FIELD_W],
				m_tdata[SLOT_FIELD_W + LIVE_FIELD_W +: ORPHAN_W]);
	end

	// APB write, then read back; only called while nothing is in flight
	task automatic reg_write(input logic idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.armed = value[0];
		// read-back transaction
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(value[0]))
			sb.report($sformatf("register %0d read back %0h, wrote %0h", idx, prdata, value));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// One input transaction. tvalid is never dropped between back-to-back
	// transactions, only during a random hold-off or a drain.
	task automatic send_item(input logic op, input logic [KEY_W-1:0] k,
			input logic [SIZE_W-1:0] sz, output status_t st);
		int hit;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {sz, k};
		do @(posedge clk); while (!s_tready);
		st = sb.note_item(op, k, sz);
		// keep key pools in step with the model
		if (st == ST_NEW) begin
			live_q.push_back(k);
		end else if (st == ST_ERASED) begin
			hit = -1;
			for (int i = 0; i < live_q.size(); i++)
				if (live_q[i] == k)
					hit = i;
			if (hit >= 0)
				live_q.delete(hit);
			dead_q.push_back(k);
		end
	endtask

	// hold the sender until every expected result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.result_q.size() != 0)
			@(posedge clk);
	endtask

	// Mostly well-formed traffic: inserts of fresh keys, replacements and frees
	// of live keys, re-use of erased keys; the rest is orphans, null keys and all-ones keys.
	task automatic random_item();
		int unsigned      pick;
		logic             op;
		logic [KEY_W-1:0] k;
		logic [SIZE_W-1:0] sz;
		status_t          st;
		pick = $urandom_range(99);
		op   = OP_INSERT;
		k    = {$urandom, $urandom};
		sz   = SIZE_W'({$urandom, $urandom});
		if (pick < 40) begin
			// fresh key
		end else if (pick < 52) begin
			if (live_q.size() != 0)
				k = live_q[$urandom_range(live_q.size() - 1)];
		end else if (pick < 78) begin
			op = OP_ERASE;
			if (live_q.size() != 0)
				k = live_q[$urandom_range(live_q.size() - 1)];
		end else if (pick < 86) begin
			// erased key: double free or re-insert into its own tombstone
			op = logic'($urandom_range(1));
			if (dead_q.size() != 0)
				k = dead_q[$urandom_range(dead_q.size() - 1)];
		end else if (pick < 93) begin
			op = OP_ERASE;
		end else if (pick < 97) begin
			op = logic'($urandom_range(1));
			k  = NULL_KEY;
		end else begin
			op = logic'($urandom_range(1));
			k  = ONES_KEY;
		end
		send_item(op, k, sz, st);
	endtask

	task automatic run_random(input int n);
		for (int i = 0; i < n; i++) begin
			// one full drain mid-phase
			if (i == n / 2)
				drain();
			random_item();
		end
	endtask

	// next key after 'from' that hashes to the same home slot as 'base'
	function automatic logic [KEY_W-1:0] same_home_key(logic [KEY_W-1:0] base,
			logic [KEY_W-1:0] from);
		logic [KEY_W-1:0] k;
		k = from;
		while (sb.home_of(k) != sb.home_of(base) || k == base)
			k++;
		return k;
	endfunction

	initial begin
		status_t          st;
		logic [KEY_W-1:0] key_a;
		logic [KEY_W-1:0] key_b;
		logic [KEY_W-1:0] key_c;
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 22;
		recv_idle = 55;

		// disarmed after reset: both ops ignored
		send_item(OP_INSERT, 64'h0000_7f00_dead_0040, 48'h40, st);
		send_item(OP_ERASE, 64'h0000_7f00_dead_0040, '0, st);
		drain();
		reg_write(REG_TRACKING, 32'd1);

		// directed: empty-table free, null keys, all-ones key, replace, reuse
		send_item(OP_ERASE, 64'h0000_7f00_dead_0040, '0, st);
		send_item(OP_INSERT, NULL_KEY, MAX_SIZE, st);
		send_item(OP_ERASE, NULL_KEY, '0, st);
		send_item(OP_INSERT, ONES_KEY, MAX_SIZE, st);
		send_item(OP_INSERT, ONES_KEY, '0, st);
		send_item(OP_INSERT, 64'h1, 48'h1, st);
		send_item(OP_INSERT, 64'h8000_0000_0000_0000, 48'h8000_0000_0000, st);
		send_item(OP_ERASE, ONES_KEY, '0, st);
		send_item(OP_ERASE, ONES_KEY, '0, st);
		send_item(OP_INSERT, ONES_KEY, 48'h1234_5678_9abc, st);
		send_item(OP_ERASE, 64'h1, '0, st);
		send_item(OP_ERASE, 64'h2, '0, st);
		send_item(OP_ERASE, 64'h8000_0000_0000_0000, '0, st);
		send_item(OP_INSERT, 64'h1, 48'h10, st);
		// colliding keys: b lands past a, a is freed, c takes a's tombstone
		key_a = 64'h1;
		key_b = same_home_key(key_a, 64'h2);
		key_c = same_home_key(key_a, key_b + 1);
		send_item(OP_INSERT, key_b, 48'h20, st);
		send_item(OP_ERASE, key_a, '0, st);
		send_item(OP_INSERT, key_c, 48'h30, st);
		send_item(OP_ERASE, key_b, '0, st);
		send_item(OP_INSERT, key_b, 48'h40, st);
		send_item(OP_ERASE, key_c, '0, st);

		run_random(RANDOM_ITEMS / 3);
		drain();

		// disarm for a short burst, then re-arm
		reg_write(REG_TRACKING, 32'd0);
		repeat (IGNORED_RUN) random_item();
		drain();
		reg_write(REG_TRACKING, 32'd1);

		send_idle = 55;
		recv_idle = 22;
		run_random(RANDOM_ITEMS / 3);
		drain();

		send_idle = 0;
		recv_idle = 0;
		run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

		// tail: fresh insert, then replace, free and re-insert of a live key
		send_item(OP_INSERT, {$urandom, $urandom}, MAX_SIZE, st);
		key_a = live_q[0];
		send_item(OP_INSERT, key_a, 48'h55, st);
		send_item(OP_ERASE, key_a, '0, st);
		send_item(OP_INSERT, key_a, 48'h66, st);
		repeat (20) random_item();

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.result_q.size() == 0)
			$display("PASS open_address_pointer_map");
		else
			$display("FAIL open_address_pointer_map");
		$finish;
	end

endmodule
